/* rtl/lccd_pkg.sv */
package lccd_pkg;

    localparam int KEY_W = 32;
    localparam int CAP_W = 5;
    localparam int OUT_SLOT_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_HIT   = 2'd0;
    localparam t_status STATUS_MISS  = 2'd1;
    localparam t_status STATUS_RANGE = 2'd2;

    typedef logic t_cfg_index;
    localparam t_cfg_index CFG_CAPACITY = 1'b0;
    localparam t_cfg_index CFG_CLUSTERS = 1'b1;

    // Control from the sequencer to every cell of the row.
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic any_hit;
    } t_ctrl;

    // Status rippling down the row from cell to cell.
    typedef struct packed {
        logic hit;
        logic done;
        logic sel_valid;
    } t_link;

endpackage

/* rtl/lru_cluster_cache_directory.sv */
// Fully associative LRU directory for disk cluster numbers.
// A request word is taken on a rising edge with start high and busy low; busy
// then stays high through the compare and update states, so no new request is
// taken until the last has left the update state. The entries sit in a row of
// WAYS cells ordered by recency. In the compare state every cell compares its
// key with the request and the hit flag ripples down the row; in the update
// state the target is found by a second ripple through the row and, for an
// in-range key, all cells up to it shift one place, the front cell taking the
// request. Row length sets the depth of both ripple paths. The result word
// (status, slot, eviction flag and key) is registered as the update state
// ends and is shown on the o_ result ports for exactly one cycle with o_strobe high.
// The receiver cannot stall; results are never held back.
// Configuration writes (capacity, cluster count) go through the cfg channel,
// which is always ready; write only while busy is low and no result is pending.
// Synchronous reset empties the directory, sets the capacity to 16 and the
// cluster count to all ones. No clearing pass is needed after reset.
module lru_cluster_cache_directory #(
    parameter int WAYS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lccd_pkg::KEY_W-1:0]        i_cluster_key,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  lccd_pkg::t_cfg_index              i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    output logic                              o_strobe,
    output lccd_pkg::t_status                 o_status,
    output logic [lccd_pkg::OUT_SLOT_W-1:0]   o_slot,
    output logic                              o_evicted,
    output logic [lccd_pkg::KEY_W-1:0]        o_evicted_key
);
    import lccd_pkg::*;

    localparam int SLOT_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    t_state             r_state;
    t_state             n_state;
    logic [CAP_W-1:0]   r_cache_capacity;
    logic [KEY_W-1:0]   r_cluster_count;
    logic [KEY_W-1:0]   r_key;
    logic               r_oor;
    logic               r_any_hit;
    logic [CAP_W-1:0]   eff_cap;
    t_ctrl              ctrl;
    logic               accept;

    logic [KEY_W-1:0]   cell_key   [WAYS];
    logic [SLOT_W-1:0]  cell_slot  [WAYS];
    logic [WAYS-1:0]    cell_valid;
    t_link              link       [WAYS+1];
    logic [KEY_W-1:0]   sel_key    [WAYS+1];
    logic [SLOT_W-1:0]  sel_slot   [WAYS+1];

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Capacity zero acts as one, and anything above the row length as WAYS.
    always_comb begin
        if (r_cache_capacity == '0) begin
            eff_cap = CAP_W'(1);
        end else if (32'(r_cache_capacity) > 32'(WAYS)) begin
            eff_cap = CAP_W'(WAYS);
        end else begin
            eff_cap = r_cache_capacity;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = accept ? ST_CMP : ST_IDLE;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy         = 1'b0;
        ctrl.cmp_en  = 1'b0;
        ctrl.upd_en  = 1'b0;
        ctrl.any_hit = r_any_hit;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_CMP: begin
                busy        = 1'b1;
                ctrl.cmp_en = 1'b1;
            end
            ST_UPD: begin
                busy        = 1'b1;
                ctrl.upd_en = !r_oor;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_cache_capacity <= CAP_W'(16);
            r_cluster_count  <= '1;
            r_any_hit        <= 1'b0;
            o_strobe         <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == ST_UPD);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_CAPACITY: r_cache_capacity <= i_cfg_data[CAP_W-1:0];
                    CFG_CLUSTERS: r_cluster_count  <= i_cfg_data;
                    default:      r_cluster_count  <= r_cluster_count;
                endcase
            end
            if (ctrl.cmp_en) begin
                r_any_hit <= link[WAYS].hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_cluster_key;
            r_oor <= i_cluster_key >= r_cluster_count;
        end
        if (r_state == ST_UPD) begin
            if (r_oor) begin
                o_status      <= STATUS_RANGE;
                o_slot        <= '0;
                o_evicted     <= 1'b0;
                o_evicted_key <= '0;
            end else begin
                o_status      <= r_any_hit ? STATUS_HIT : STATUS_MISS;
                o_slot        <= OUT_SLOT_W'(32'(sel_slot[WAYS]));
                o_evicted     <= !r_any_hit && link[WAYS].sel_valid;
                o_evicted_key <= (!r_any_hit && link[WAYS].sel_valid) ? sel_key[WAYS] : '0;
            end
        end
    end

    assign link[0].hit       = 1'b0;
    assign link[0].done      = 1'b0;
    assign link[0].sel_valid = 1'b0;
    assign sel_key[0]        = '0;
    assign sel_slot[0]       = '0;

    for (genvar i = 0; i < WAYS; i++) begin : g_row
        logic [KEY_W-1:0]  prev_key;
        logic [SLOT_W-1:0] prev_slot;
        logic              prev_valid;
        logic              next_valid;

        if (i == 0) begin : g_front
            // The front cell takes the request and the slot found at the target.
            assign prev_key   = r_key;
            assign prev_slot  = sel_slot[WAYS];
            assign prev_valid = 1'b1;
        end else begin : g_inner
            assign prev_key   = cell_key[i-1];
            assign prev_slot  = cell_slot[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        if (i == WAYS - 1) begin : g_tail
            assign next_valid = 1'b0;
        end else begin : g_body
            assign next_valid = cell_valid[i+1];
        end

        lccd_cell #(
            .INDEX  (i),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_req_key    (r_key),
            .i_cap        (eff_cap),
            .i_prev_key   (prev_key),
            .i_prev_slot  (prev_slot),
            .i_prev_valid (prev_valid),
            .i_next_valid (next_valid),
            .i_link       (link[i]),
            .i_sel_key    (sel_key[i]),
            .i_sel_slot   (sel_slot[i]),
            .o_key        (cell_key[i]),
            .o_slot       (cell_slot[i]),
            .o_valid      (cell_valid[i]),
            .o_link       (link[i+1]),
            .o_sel_key    (sel_key[i+1]),
            .o_sel_slot   (sel_slot[i+1])
        );
    end

    // An in-range request always finds exactly one target in the row.
    a_target_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && !r_oor) |-> link[WAYS].done)
        else $error("no target position found for request");

    // Valid entries always form a prefix of the row.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, cell_valid} + {{WAYS{1'b0}}, 1'b1}))
        else $error("valid entries do not form a prefix");

    a_strobe_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> o_strobe)
        else $error("result word missing after update");

    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_evicted) |-> (o_status == STATUS_MISS))
        else $error("eviction reported without a miss");

    a_hit_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_any_hit) |=> $stable(cell_valid))
        else $error("a hit changed the number of held entries");

endmodule

/* rtl/lccd_cell.sv */
module lccd_cell #(
    parameter int INDEX  = 0,
    parameter int SLOT_W = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lccd_pkg::t_ctrl               i_ctrl,
    input  logic [lccd_pkg::KEY_W-1:0]    i_req_key,
    input  logic [lccd_pkg::CAP_W-1:0]    i_cap,
    input  logic [lccd_pkg::KEY_W-1:0]    i_prev_key,
    input  logic [SLOT_W-1:0]             i_prev_slot,
    input  logic                          i_prev_valid,
    input  logic                          i_next_valid,
    input  lccd_pkg::t_link               i_link,
    input  logic [lccd_pkg::KEY_W-1:0]    i_sel_key,
    input  logic [SLOT_W-1:0]             i_sel_slot,
    output logic [lccd_pkg::KEY_W-1:0]    o_key,
    output logic [SLOT_W-1:0]             o_slot,
    output logic                          o_valid,
    output lccd_pkg::t_link               o_link,
    output logic [lccd_pkg::KEY_W-1:0]    o_sel_key,
    output logic [SLOT_W-1:0]             o_sel_slot
);
    import lccd_pkg::*;

    logic [KEY_W-1:0]  r_key;
    logic [SLOT_W-1:0] r_slot;
    logic              r_valid;
    logic              r_match;
    logic              match;
    logic              first_invalid;
    logic              last_valid;
    logic              below_cap;
    logic              fills_cap;
    logic              is_tgt;

    assign match         = r_valid && (r_key == i_req_key);
    assign first_invalid = !r_valid && i_prev_valid;
    assign last_valid    = r_valid && !i_next_valid;
    assign below_cap     = 32'(INDEX) < 32'(i_cap);
    assign fills_cap     = (32'(INDEX) + 32'd1) >= 32'(i_cap);

    // On a miss the target is the first free position while there is room,
    // otherwise the least recent valid entry.
    always_comb begin
        if (i_ctrl.any_hit) begin
            is_tgt = !i_link.done && r_match;
        end else begin
            is_tgt = !i_link.done &&
                     ((first_invalid && below_cap) || (last_valid && fills_cap));
        end
    end

    always_comb begin
        o_link.hit       = i_link.hit || match;
        o_link.done      = i_link.done || is_tgt;
        o_link.sel_valid = is_tgt ? r_valid : i_link.sel_valid;
        o_sel_key        = is_tgt ? r_key : i_sel_key;
        o_sel_slot       = is_tgt ? r_slot : i_sel_slot;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= match;
        end
        if (i_ctrl.upd_en && !i_link.done) begin
            r_key <= i_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= SLOT_W'(INDEX);
        end else if (i_ctrl.upd_en && !i_link.done) begin
            r_valid <= i_prev_valid;
            r_slot  <= i_prev_slot;
        end
    end

    assign o_key   = r_key;
    assign o_slot  = r_slot;
    assign o_valid = r_valid;

endmodule

/* tb/lru_cluster_cache_directory_tb.sv */
`timescale 1ns / 1ps

module lru_cluster_cache_directory_tb;
    import lccd_pkg::*;

    localparam int WAYS = 16;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_dir_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_cluster_key;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_strobe;
    t_status     o_status;
    logic [3:0]  o_slot;
    logic        o_evicted;
    logic [31:0] o_evicted_key;

    lru_cluster_cache_directory #(.WAYS(WAYS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cluster_key (i_cluster_key),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    // Shadow copy of the directory, ordered by recency (0 = most recent).
    logic [31:0] dir_key   [WAYS];
    logic        dir_valid [WAYS];
    logic [3:0]  dir_slot  [WAYS];
    logic [4:0]  shadow_capacity;
    logic [31:0] shadow_clusters;

    t_dir_result pending_lookups[$];
    int          error_count;
    int          sent_count;
    int          cfg_count;
    int          hit_count;
    int          insert_count;
    int          writeback_count;
    int          reject_count;
    int          sender_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void promote_entry(int pos, logic [31:0] key, logic [3:0] slot);
        for (int i = pos; i > 0; i--) begin
            dir_key[i]   = dir_key[i - 1];
            dir_slot[i]  = dir_slot[i - 1];
            dir_valid[i] = dir_valid[i - 1];
        end
        dir_key[0]   = key;
        dir_slot[0]  = slot;
        dir_valid[0] = 1'b1;
    endfunction

    function automatic t_dir_result lookup_cluster(logic [31:0] key);
        t_dir_result r;
        int          cap;
        int          held;
        int          pos;
        logic        found;
        r     = '0;
        held  = 0;
        pos   = 0;
        found = 1'b0;
        if (key >= shadow_clusters) begin
            r.status = STATUS_RANGE;
            return r;
        end
        cap = shadow_capacity;
        if (cap < 1) cap = 1;
        if (cap > WAYS) cap = WAYS;
        for (int i = 0; i < WAYS; i++) begin
            if (dir_valid[i]) begin
                held++;
                if (!found && dir_key[i] == key) begin
                    found = 1'b1;
                    pos   = i;
                end
            end
        end
        if (found) begin
            r.status = STATUS_HIT;
            r.slot   = dir_slot[pos];
            promote_entry(pos, key, r.slot);
        end else if (held < cap) begin
            r.status = STATUS_MISS;
            r.slot   = dir_slot[held];
            promote_entry(held, key, r.slot);
        end else begin
            // Full: the least recent entry gives up its slot for write back.
            r.status      = STATUS_MISS;
            r.slot        = dir_slot[held - 1];
            r.evicted     = 1'b1;
            r.evicted_key = dir_key[held - 1];
            promote_entry(held - 1, key, r.slot);
        end
        return r;
    endfunction

    // Result checker: a word is taken at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        t_dir_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result word: status %0d slot %0d", o_status, o_slot);
                error_count++;
            end else begin
                want = pending_lookups.pop_front();
                case (want.status)
                    STATUS_HIT:   hit_count++;
                    STATUS_MISS:  insert_count++;
                    STATUS_RANGE: reject_count++;
                    default: ;
                endcase
                if (want.evicted) writeback_count++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    error_count++;
                end
                if (o_evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, o_evicted);
                    error_count++;
                end
                if (o_evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %08h, got %08h",
                           want.evicted_key, o_evicted_key);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(logic [31:0] key);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_cluster_key <= key;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pending_lookups.push_back(lookup_cluster(key));
        sent_count++;
    endtask

    // Lets every outstanding word come back before registers change.
    task automatic drain_directory();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == CFG_CAPACITY) shadow_capacity = data[4:0];
        else shadow_clusters = data;
        cfg_count++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_fill_and_hit();
        send_request(32'd0);
        send_request(32'hFFFF_FFFE);
        send_request(32'd5);
        send_request(32'd0);
        send_request(32'd5);
        // The all-ones key is never below the reset cluster count.
        send_request(32'hFFFF_FFFF);
        drain_directory();
    endtask

    task automatic test_range_limits();
        write_register(CFG_CLUSTERS, 32'd0);
        send_request(32'd0);
        send_request(32'h8000_0000);
        drain_directory();
        write_register(CFG_CLUSTERS, 32'd10);
        send_request(32'd9);
        send_request(32'd10);
        send_request(32'd0);
        drain_directory();
    endtask

    task automatic test_capacity_limits();
        // Capacity zero acts as one, and the number of entries held stays as it was.
        write_register(CFG_CAPACITY, 32'd0);
        send_request(32'd1);
        send_request(32'd9);
        send_request(32'd2);
        send_request(32'd3);
        drain_directory();
        write_register(CFG_CAPACITY, 32'd1);
        send_request(32'd4);
        send_request(32'd4);
        drain_directory();
        write_register(CFG_CAPACITY, 32'd31);
        write_register(CFG_CLUSTERS, 32'hFFFF_FFFF);
        send_request(32'd100);
        send_request(32'd101);
        send_request(32'd102);
        drain_directory();
    endtask

    task automatic test_random_traffic(int idle_pct);
        logic [31:0] cap_data;
        logic [31:0] clusters;
        logic [31:0] key_pool[24];
        int          pool_n;
        int          pick;
        logic [31:0] key;
        sender_idle_pct = idle_pct;
        for (int chunk = 0; chunk < 4; chunk++) begin
            cap_data = $urandom;
            case ($urandom_range(4))
                0: cap_data[4:0] = 5'd1;
                1: cap_data[4:0] = 5'd16;
                2: cap_data[4:0] = 5'd31;
                3: cap_data[4:0] = 5'($urandom_range(2, 8));
                default: ;
            endcase
            case ($urandom_range(3))
                0: clusters = 32'hFFFF_FFFF;
                1: clusters = $urandom_range(4, 40);
                2: clusters = $urandom | 32'h0000_0100;
                default: clusters = 32'h8000_0000 + $urandom_range(64);
            endcase
            write_register(CFG_CAPACITY, cap_data);
            write_register(CFG_CLUSTERS, clusters);
            // A small key set of up to 24 keys, drawn from the cluster range, keeps hits
            // and evictions both frequent.
            pool_n = $urandom_range(1, 24);
            for (int i = 0; i < 24; i++) key_pool[i] = $urandom % clusters;
            for (int n = 0; n < 50; n++) begin
                pick = $urandom_range(99);
                if (pick < 75) key = key_pool[$urandom_range(pool_n - 1)];
                else if (pick < 85) key = $urandom;
                else if (pick < 95) key = clusters - $urandom_range(1);
                else key = 32'hFFFF_FFFF;
                send_request(key);
            end
            drain_directory();
        end
    endtask

    initial begin
        error_count     = 0;
        sent_count      = 0;
        cfg_count       = 0;
        hit_count       = 0;
        insert_count    = 0;
        writeback_count = 0;
        reject_count    = 0;
        sender_idle_pct = 0;
        shadow_capacity = 5'd16;
        shadow_clusters = 32'hFFFF_FFFF;
        for (int i = 0; i < WAYS; i++) begin
            dir_key[i]   = '0;
            dir_valid[i] = 1'b0;
            dir_slot[i]  = 4'(i);
        end
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cluster_key = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_CAPACITY;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_hit();
        test_range_limits();
        test_capacity_limits();
        test_random_traffic(13);
        test_random_traffic(60);
        test_random_traffic(0);
        drain_directory();

        $display("tb: %0d requests over %0d register writes", sent_count, cfg_count);
        $display("tb: %0d hits, %0d inserts (%0d with write back), %0d rejected keys",
                 hit_count, insert_count, writeback_count, reject_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
